@@ rtl/core/cbtc_pkg.sv @@
// Shared types and constants for the complete binary tree check unit.
package cbtc_pkg;

  localparam int DEF_MAX_NODES = 32;
  localparam int IDX_W         = 5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_QRD,
    ST_TRD,
    ST_VISL,
    ST_VISR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic q_read;
    logic t_read;
    logic visit_l;
    logic visit_r;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic q_empty;
    logic slot_fail;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/cbtc_ctrl.sv @@
// Controller state machine that sequences loading, root search and the level-order walk.
module cbtc_ctrl import cbtc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_node,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_node) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_QRD;
      end
      ST_QRD: begin
        state_nxt = sts.q_empty ? ST_FIN : ST_TRD;
      end
      ST_TRD: begin
        state_nxt = ST_VISL;
      end
      ST_VISL: begin
        state_nxt = sts.slot_fail ? ST_FIN : ST_VISR;
      end
      ST_VISR: begin
        state_nxt = sts.slot_fail ? ST_FIN : ST_QRD;
      end
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_QRD: begin
        cmd.q_read = !sts.q_empty;
      end
      ST_TRD: begin
        cmd.t_read = 1'b1;
      end
      ST_VISL: begin
        cmd.visit_l = 1'b1;
      end
      ST_VISR: begin
        cmd.visit_r = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/core/cbtc_dpath.sv @@
// Datapath holding the child tables, child marks, walk queue and the result register.
module cbtc_dpath import cbtc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_left_present,
  input  logic [IDX_W-1:0] in_left_index,
  input  logic             in_right_present,
  input  logic [IDX_W-1:0] in_right_index,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_is_complete,
  output logic [IDX_W-1:0] out_node_index
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NW = (AW > IDX_W) ? AW : IDX_W;
  localparam int XW = (CW > NW) ? CW : NW;
  localparam int SW = IDX_W + 1;

  logic [SW-1:0]        left_mem  [MAX_NODES];
  logic [SW-1:0]        right_mem [MAX_NODES];
  logic [NW-1:0]        queue_mem [MAX_NODES];
  logic [SW-1:0]        left_rd_r, right_rd_r;
  logic [NW-1:0]        q_rd_r;
  logic                 node_ok_r;
  logic [NW-1:0]        last_r, root_r;
  logic [MAX_NODES-1:0] mark_r, mark_nxt;
  logic [CW-1:0]        count_r, head_r, tail_r;
  logic [AW-1:0]        scan_idx_r;
  logic                 gap_r, fail_r, out_valid_r;
  logic                 is_complete_r;
  logic [IDX_W-1:0]     node_index_r;

  logic                 count_full, do_store;
  logic                 scan_hit, scan_end, scan_done, walk_start;
  logic [NW-1:0]        root_val;
  logic [SW-1:0]        cur_slot;
  logic                 visiting, slot_present, slot_fail, enqueue;
  logic                 q_we;
  logic [AW-1:0]        q_wa;
  logic [NW-1:0]        q_wd;

  assign count_full = (count_r == CW'(MAX_NODES));
  assign do_store   = cmd.load && !count_full;

  always_comb begin
    mark_nxt = mark_r;
    if (cmd.finish) begin
      mark_nxt = '0;
    end else if (do_store) begin
      if (in_left_present && (XW'(in_left_index) < XW'(MAX_NODES))) begin
        mark_nxt[AW'(in_left_index)] = 1'b1;
      end
      if (in_right_present && (XW'(in_right_index) < XW'(MAX_NODES))) begin
        mark_nxt[AW'(in_right_index)] = 1'b1;
      end
    end
  end

  // Root search: lowest unmarked loaded node, node 0 when none is unmarked.
  assign scan_hit   = !mark_r[scan_idx_r];
  assign scan_end   = ((CW'(scan_idx_r) + CW'(1)) == count_r);
  assign scan_done  = scan_hit || scan_end;
  assign walk_start = cmd.scan && scan_done;
  assign root_val   = scan_hit ? NW'(scan_idx_r) : '0;

  assign visiting     = cmd.visit_l || cmd.visit_r;
  always_comb begin
    if (!node_ok_r) begin
      cur_slot = '0;
    end else if (cmd.visit_r) begin
      cur_slot = right_rd_r;
    end else begin
      cur_slot = left_rd_r;
    end
  end
  assign slot_present = cur_slot[SW-1];
  assign slot_fail    = slot_present && (gap_r || (tail_r >= count_r));
  assign enqueue      = visiting && slot_present && !slot_fail;

  always_comb begin
    q_we = walk_start || enqueue;
    q_wa = walk_start ? '0 : AW'(tail_r);
    q_wd = walk_start ? root_val : NW'(cur_slot[IDX_W-1:0]);
  end

  assign sts.scan_done = scan_done;
  assign sts.q_empty   = (head_r >= tail_r);
  assign sts.slot_fail = slot_fail;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (do_store) begin
      left_mem[AW'(count_r)]  <= in_left_present  ? {1'b1, in_left_index}  : '0;
      right_mem[AW'(count_r)] <= in_right_present ? {1'b1, in_right_index} : '0;
    end
    if (cmd.t_read) begin
      left_rd_r  <= left_mem[AW'(q_rd_r)];
      right_rd_r <= right_mem[AW'(q_rd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    if (cmd.q_read) begin
      q_rd_r <= queue_mem[AW'(head_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (walk_start) begin
      root_r <= root_val;
    end
    if (cmd.t_read) begin
      last_r    <= q_rd_r;
      node_ok_r <= (XW'(q_rd_r) < XW'(count_r));
    end
    if (cmd.finish) begin
      is_complete_r <= !fail_r;
      node_index_r  <= fail_r ? root_r[IDX_W-1:0] : last_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      gap_r       <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
      if (cmd.finish) begin
        count_r <= '0;
      end else if (do_store) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan && !scan_done) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
      if (walk_start) begin
        head_r <= '0;
      end else if (cmd.q_read) begin
        head_r <= head_r + CW'(1);
      end
      if (walk_start) begin
        tail_r <= CW'(1);
      end else if (enqueue) begin
        tail_r <= tail_r + CW'(1);
      end
      if (walk_start || cmd.finish) begin
        gap_r <= 1'b0;
      end else if (visiting && !slot_present) begin
        gap_r <= 1'b1;
      end
      if (walk_start) begin
        fail_r <= 1'b0;
      end else if (visiting && slot_fail) begin
        fail_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_complete = is_complete_r;
  assign out_node_index  = node_index_r;

endmodule

@@ rtl/core/complete_binary_tree_check_unit.sv @@
// Entries load at one beat per cycle; the beat marked last starts the check. The controller then
// scans for the root, and for each node visited reads the queue, reads the child tables and
// visits the left and then the right child; a failed walk stops early, and a result still
// waiting outside delays the new one until it is taken.
// Throughput: one entry per cycle while loading; input stalls until the result is registered.
// Reset is synchronous, active low: marks, counts and pointers clear; tables are left as they are.
module complete_binary_tree_check_unit import cbtc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_left_present,
  input  logic [IDX_W-1:0] in_left_index,
  input  logic             in_right_present,
  input  logic [IDX_W-1:0] in_right_index,
  input  logic             in_last_node,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_complete,
  output logic [IDX_W-1:0] out_node_index
);

  // The controller only decides which step runs each cycle; all storage and
  // comparisons sit in the datapath, which reports back through a small status struct.
  cmd_t cmd;
  sts_t sts;

  cbtc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // The result sits in an output register, so a fresh tree may start loading while
  // the previous beat still waits on the far side.
  cbtc_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_left_present  (in_left_present),
    .in_left_index    (in_left_index),
    .in_right_present (in_right_present),
    .in_right_index   (in_right_index),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_is_complete  (out_is_complete),
    .out_node_index   (out_node_index)
  );

`ifndef SYNTH
  // Only one datapath step may be commanded in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command at once");

  // The queue is never read once the walk has drained it.
  a_q_read: assert property (@(posedge clk) disable iff (!rst_n) cmd.q_read |-> !sts.q_empty)
    else $error("walk queue read while empty");

  // Finishing a check always presents a result in the next cycle.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> out_valid)
    else $error("finished check did not raise a result");
`endif

endmodule
